// ----- rtl/core/mbq_pkg.sv -----
// Shared types and constants of the per-task mailbox queues.
package mbq_pkg;

  localparam int unsigned ID_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned NUM_QUEUES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned PAYLOAD_WIDTH_DEF = 32;

  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_RECV = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_ID  = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_NO_TASK = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    K_SEND    = 2'd0,
    K_RECV    = 2'd1,
    K_BAD_ID  = 2'd2,
    K_NO_TASK = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] payload;
  } req_t;

endpackage

// ----- rtl/core/mbq_if.sv -----
// Valid/ready channel interfaces for mailbox requests and responses.
interface mbq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [mbq_pkg::ID_W-1:0]    queue_id;
  logic [mbq_pkg::DATA_W-1:0]  payload;

  modport source (output valid, action, queue_id, payload, input ready);
  modport sink (input valid, action, queue_id, payload, output ready);
endinterface

interface mbq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mbq_pkg::STATUS_W-1:0] status;
  logic [mbq_pkg::DATA_W-1:0]   msg_data;
  logic [mbq_pkg::ID_W-1:0]     receiver;

  modport source (output valid, status, msg_data, receiver, input ready);
  modport sink (input valid, status, msg_data, receiver, output ready);
endinterface

// ----- rtl/core/mbq_front.sv -----
// Request classification and the two-entry queue that feeds the back end.
module mbq_front #(
  parameter int unsigned NUM_QUEUES = mbq_pkg::NUM_QUEUES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       action_i,
  input  logic [mbq_pkg::ID_W-1:0]   queue_id_i,
  input  logic [mbq_pkg::DATA_W-1:0] payload_i,
  output logic                       req_valid_o,
  input  logic                       req_ready_i,
  output mbq_pkg::req_t              req_o
);
  import mbq_pkg::*;

  req_t       buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  req_t       req_new;
  logic       push, pop, id_zero, id_high;

  assign id_zero = (queue_id_i == '0);
  assign id_high = (queue_id_i > ID_W'(NUM_QUEUES));

  always_comb begin
    req_new.id = queue_id_i;
    req_new.payload = payload_i;
    if (action_i == ACT_SEND) begin
      req_new.kind = (id_zero || id_high) ? K_BAD_ID : K_SEND;
    end else if (id_zero) begin
      req_new.kind = K_NO_TASK;
    end else begin
      req_new.kind = id_high ? K_BAD_ID : K_RECV;
    end
  end

  assign ready_o = (count_q != 2'd2);
  assign req_valid_o = (count_q != 2'd0);
  assign req_o = buf_q[rd_ptr_q];
  assign push = valid_i && ready_o;
  assign pop = req_valid_o && req_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= req_new;
    end
  end

endmodule

// ----- rtl/core/mbq_back.sv -----
// Queue pointers, message memory and the response register.
module mbq_back #(
  parameter int unsigned NUM_QUEUES    = mbq_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH   = mbq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = mbq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  mbq_pkg::req_t                req_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [mbq_pkg::STATUS_W-1:0] status_o,
  output logic [mbq_pkg::DATA_W-1:0]   msg_data_o,
  output logic [mbq_pkg::ID_W-1:0]     receiver_o
);
  import mbq_pkg::*;

  localparam int unsigned QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned STORE_W = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;
  localparam int unsigned WORD_W = STORE_W + ID_W;

  logic [PTR_W-1:0]  head_q [NUM_QUEUES];
  logic [PTR_W-1:0]  tail_q [NUM_QUEUES];
  logic [CNT_W-1:0]  fill_q [NUM_QUEUES];
  logic [WORD_W-1:0] mem_q [SLOTS];
  logic [WORD_W-1:0] rd_q;

  logic              valid_q;
  status_e           status_q, status_d;
  logic              hit_q;

  logic              fire, in_range, full, empty, wr_en, rd_en;
  logic [QIDX_W-1:0] qi;
  logic [PTR_W-1:0]  ptr, ptr_next;
  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] addr;

  assign req_ready_o = !valid_q || ready_i;
  assign fire = req_valid_i && req_ready_o;
  assign in_range = (req_i.kind == K_SEND) || (req_i.kind == K_RECV);
  assign qi = in_range ? QIDX_W'(req_i.id - ID_W'(1)) : '0;
  assign fill = fill_q[qi];
  assign full = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign ptr = (req_i.kind == K_SEND) ? tail_q[qi] : head_q[qi];
  assign ptr_next = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  assign addr = ADDR_W'(32'(qi) * QUEUE_DEPTH + 32'(ptr));

  always_comb begin
    status_d = ST_OK;
    case (req_i.kind)
      K_SEND:    status_d = full ? ST_FULL : ST_OK;
      K_RECV:    status_d = empty ? ST_EMPTY : ST_OK;
      K_BAD_ID:  status_d = ST_BAD_ID;
      K_NO_TASK: status_d = ST_NO_TASK;
      default:   status_d = ST_BAD_ID;
    endcase
  end

  assign wr_en = fire && (req_i.kind == K_SEND) && !full;
  assign rd_en = fire && (req_i.kind == K_RECV) && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (wr_en) begin
      tail_q[qi] <= ptr_next;
      fill_q[qi] <= fill + CNT_W'(1);
    end else if (rd_en) begin
      head_q[qi] <= ptr_next;
      fill_q[qi] <= fill - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= {req_i.id, req_i.payload[STORE_W-1:0]};
    end
    if (rd_en) begin
      rd_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      status_q <= ST_OK;
      hit_q <= 1'b0;
    end else if (req_ready_o) begin
      valid_q <= req_valid_i;
      status_q <= status_d;
      hit_q <= rd_en;
    end
  end

  assign valid_o = valid_q;
  assign status_o = status_q;
  assign msg_data_o = hit_q ? DATA_W'(rd_q[STORE_W-1:0]) : '0;
  assign receiver_o = hit_q ? rd_q[WORD_W-1 -: ID_W] : '0;

endmodule

// ----- rtl/core/per_task_mailbox_queues_core.sv -----
// Top level of the per-task mailbox: one ring queue per task behind two channels.
//
// Requests arrive on req_i: action selects send or receive, queue_id names
// the queue (1 to NUM_QUEUES) and payload carries the message for a send.
// Every request transaction yields exactly one response transaction on
// rsp_o, in request order, carrying a status, the message data and the
// receiver id (both zero unless a receive succeeded).
// A request is first held in a two-entry queue in the front end, then the
// back end reads and updates the queue's pointers, accesses the message
// memory and loads the response register in the same cycle.
// A request is registered in the front queue and then in the response register;
// one request per cycle is sustained while rsp_o is not stalled.
// Reset empties every queue at once by clearing the pointers and fill
// counts; the message memory is not cleared and no start-up pass is needed.
// When rsp_o is stalled the response register holds, the back end stops
// and the front queue fills both of its entries before req_i.ready falls.
module per_task_mailbox_queues_core #(
  parameter int unsigned NUM_QUEUES    = mbq_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH   = mbq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = mbq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbq_req_if.sink   req_i,
  mbq_rsp_if.source rsp_o
);
  import mbq_pkg::*;

  req_t req;
  logic req_valid, req_ready;

  mbq_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (req_i.valid),
    .ready_o     (req_i.ready),
    .action_i    (req_i.action),
    .queue_id_i  (req_i.queue_id),
    .payload_i   (req_i.payload),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  mbq_back #(
    .NUM_QUEUES    (NUM_QUEUES),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .valid_o     (rsp_o.valid),
    .ready_i     (rsp_o.ready),
    .status_o    (rsp_o.status),
    .msg_data_o  (rsp_o.msg_data),
    .receiver_o  (rsp_o.receiver)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |-> (rsp_o.msg_data == '0) && (rsp_o.receiver == '0))
  else $error("error response carries message fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.receiver <= ID_W'(NUM_QUEUES)))
  else $error("receiver id out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && !req_ready |=> req_valid && $stable(req))
  else $error("front queue head changed while the back end stalled");

endmodule
